// File: rtl/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the streaming SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // block slots that carry the big-endian bit length
  localparam logic [3:0] LEN_HI_WORD = 4'd14;
  localparam logic [3:0] LEN_LO_WORD = 4'd15;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = IV0;
      3'd1:    v = IV1;
      3'd2:    v = IV2;
      3'd3:    v = IV3;
      default: v = IV4;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/sha1_ram.sv
// ----------------------------------------------------------------------------
// sha1_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sha1_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// Streaming SHA-1: gathers message words into a 16-word block RAM, runs the
// 80-round compression one round per cycle, pads on the final word and
// emits the five digest words.
// ----------------------------------------------------------------------------
// Input: a word that does not complete a block is taken without a stall; the
// word that completes one stalls the input through the block load, the rounds
// and the fold, so no new word is taken until that compression is done.
// Final word: one pad write per cycle up to slot 15, one or two compressions,
// then five digest words, one per cycle unless stalled.
// Reset (rst_n low, synchronous): initial chaining words, zero length, empty block.
// ----------------------------------------------------------------------------
module sha1_message_digest
  import sha1_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  state_t state_r, state_nxt;

  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [16];        // schedule window, w_r[15] newest
  logic [63:0] len_r;
  logic [3:0]  widx_r;          // next block slot to write
  logic        pad_r;           // final word seen, padding in progress
  logic        mark_r;          // 0x80 marker already placed
  logic        tail_r;          // length high word written in this block
  logic [6:0]  cnt_r;
  logic [2:0]  oidx_r;

  logic        ram_we;
  logic [3:0]  ram_wa, ram_ra;
  logic [31:0] ram_wd, ram_rd;

  logic        acc;
  logic [2:0]  cnt_eff;
  logic [31:0] cmask;
  logic [31:0] marker;
  logic [31:0] in_word;
  logic [31:0] pad_word;

  logic [31:0] f, k, t, wx, wnew, wcur;
  logic [6:0]  rnd;
  logic [3:0]  ld_idx;

  sha1_ram #(.Width(32), .Depth(16)) u_block (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign acc = in_valid && !in_stall;

  // clamp the byte count: four unless a short final word
  always_comb begin
    cnt_eff = 3'd4;
    if (in_final_item && in_byte_count < 3'd4) begin
      cnt_eff = in_byte_count;
    end
  end

  // mask the valid bytes and merge the marker into a short final word
  always_comb begin
    case (cnt_eff)
      3'd0:    cmask = 32'h0;
      3'd1:    cmask = 32'hFF000000;
      3'd2:    cmask = 32'hFFFF0000;
      3'd3:    cmask = 32'hFFFFFF00;
      default: cmask = 32'hFFFFFFFF;
    endcase
    marker  = {PAD_BYTE, 24'h0} >> {cnt_eff[1:0], 3'b000};
    in_word = in_message_word & cmask;
    if (in_final_item && !cnt_eff[2]) begin
      in_word = in_word | marker;
    end
  end

  // pick the pad word: marker, zero fill or bit length
  always_comb begin
    pad_word = 32'h0;
    if (!mark_r) begin
      pad_word = {PAD_BYTE, 24'h0};
    end else if (widx_r == LEN_HI_WORD) begin
      pad_word = len_r[63:32];
    end else if (widx_r == LEN_LO_WORD && tail_r) begin
      pad_word = len_r[31:0];
    end
  end

  // round logic
  assign rnd    = cnt_r;
  assign ld_idx = cnt_r[3:0] - 4'd1;
  assign wx     = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign wnew   = {wx[30:0], wx[31]};
  assign wcur   = (rnd < 7'd16) ? w_r[rnd[3:0]] : wnew;
  always_comb begin
    if (rnd < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r); k = K0;
    end else if (rnd < 7'd40) begin
      f = b_r ^ c_r ^ d_r;            k = K1;
    end else if (rnd < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r); k = K2;
    end else begin
      f = b_r ^ c_r ^ d_r;            k = K3;
    end
    t = {a_r[26:0], a_r[31:27]} + f + e_r + k + wcur;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && widx_r == LEN_LO_WORD) begin
          state_nxt = ST_LOAD;
        end else if (acc && in_final_item) begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD:   if (widx_r == LEN_LO_WORD) state_nxt = ST_LOAD;
      ST_LOAD:  if (cnt_r == 7'd16) state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_r == 7'd79) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!pad_r) begin
          state_nxt = ST_IDLE;
        end else if (tail_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_EMIT: if (!out_stall && oidx_r == 3'd4) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and RAM port: one write per accepted word or pad step
  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    out_valid       = (state_r == ST_EMIT);
    out_digest_word = h_r[oidx_r];
    out_word_number = oidx_r;
    out_last_word   = (oidx_r == 3'd4);
    ram_we          = 1'b0;
    ram_wa          = widx_r;
    ram_wd          = in_word;
    ram_ra          = cnt_r[3:0];
    if (state_r == ST_IDLE && in_valid) begin
      ram_we = 1'b1;
    end else if (state_r == ST_PAD) begin
      ram_we = 1'b1;
      ram_wd = pad_word;
    end
  end

  // advance state, gather, compress and emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      widx_r  <= '0;
      len_r   <= '0;
      pad_r   <= 1'b0;
      mark_r  <= 1'b0;
      tail_r  <= 1'b0;
      cnt_r   <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < 5; i++) h_r[i] <= iv_word(3'(i));
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            len_r  <= len_r + {58'd0, cnt_eff, 3'b000};
            widx_r <= widx_r + 4'd1;
            cnt_r  <= '0;
            if (in_final_item) begin
              pad_r  <= 1'b1;
              mark_r <= !cnt_eff[2];
            end
          end
        end
        ST_PAD: begin
          widx_r <= widx_r + 4'd1;
          cnt_r  <= '0;
          if (!mark_r) begin
            mark_r <= 1'b1;
          end else if (widx_r == LEN_HI_WORD) begin
            tail_r <= 1'b1;
          end
        end
        ST_LOAD: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r != 7'd0) begin
            w_r[ld_idx] <= ram_rd;
          end
          if (cnt_r == 7'd16) begin
            a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2];
            d_r <= h_r[3]; e_r <= h_r[4];
            cnt_r <= '0;
          end
        end
        ST_ROUND: begin
          cnt_r <= cnt_r + 7'd1;
          if (rnd >= 7'd16) begin
            for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
            w_r[15] <= wnew;
          end
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]};
          b_r <= a_r; a_r <= t;
        end
        ST_FOLD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          cnt_r  <= '0;
          oidx_r <= '0;
        end
        ST_EMIT: begin
          if (!out_stall) begin
            if (oidx_r == 3'd4) begin
              oidx_r <= '0;
              for (int i = 0; i < 5; i++) h_r[i] <= iv_word(3'(i));
              len_r  <= '0;
              widx_r <= '0;
              pad_r  <= 1'b0;
              mark_r <= 1'b0;
              tail_r <= 1'b0;
            end else begin
              oidx_r <= oidx_r + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word_number))
    else $error("digest word dropped under stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> in_stall)
    else $error("input accepted during rounds");
  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> cnt_r < 7'd80)
    else $error("round counter overran");

endmodule
